// ----- rtl/core/osm_pkg.sv -----
package osm_pkg;

  localparam int DIST_FRAC_BITS = 8;
  localparam int ANGLE_BITS     = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int SQRT_STEPS     = 24;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ADDR_W         = 5;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [16:0]        ONE_Q16     = 17'd65536;

  localparam logic [16:0] RST_MIN_CONF  = 17'd32768;
  localparam logic [22:0] RST_MAX_RANGE = 23'd12800;
  localparam logic [22:0] RST_LANE      = 23'd384;
  localparam logic [15:0] RST_REACT     = 16'd128;
  localparam logic [15:0] RST_DECEL     = 16'd1536;

  typedef enum logic [2:0] {
    REG_MIN_CONF  = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_LANE      = 3'd2,
    REG_REACT     = 3'd3,
    REG_DECEL     = 3'd4
  } osm_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } osm_state_e;

  typedef struct packed {
    logic [16:0] min_confidence;
    logic [22:0] max_range;
    logic [22:0] lane_half_width;
    logic [15:0] reaction_time;
    logic [15:0] max_decel;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [23:0] fwd;
    logic signed [23:0] left;
    logic               conf_ok;
    logic               lane_ok;
    logic [15:0]        heading;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        speed;
    logic               last;
  } item_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/obstacle_safety_monitor_unit.sv -----
// channel   direction  handshake                fields
// in        input      in_valid_i / in_stall_o  detection, pose, speed, last_item
// out       output     out_valid_o / out_stall_i  result of one detection
// cfg       input      psel penable pwrite      five registers at 4*index
//
// for each item in the back end, 30 cordic steps set the figure, the 24-step root
// runs beside them, the squares and the stop distance run beside them on the
// shared multiplier, four products of the rotation follow, then the output register
// takes the result; a two-entry queue lets the front take two more transfers meanwhile
// reset clears control and frame state, no clearing pass
// the back end holds its finished item while the output register is stalled
module obstacle_safety_monitor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [15:0]                detection_id_i,
  input  logic signed [23:0]         forward_dist_i,
  input  logic signed [23:0]         left_dist_i,
  input  logic [16:0]                confidence_i,
  input  logic [15:0]                heading_i,
  input  logic signed [31:0]         pose_x_i,
  input  logic signed [31:0]         pose_y_i,
  input  logic [15:0]                speed_kph_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic [15:0]                obstacle_id_o,
  output logic signed [31:0]         world_x_o,
  output logic signed [31:0]         world_y_o,
  output logic [23:0]                obstacle_range_o,
  output logic                       emergency_brake_o,
  output logic                       nearest_found_o,
  output logic [15:0]                nearest_id_o,
  output logic [23:0]                nearest_range_o,
  output logic                       frame_done_o
);
  import osm_pkg::*;

  cfg_t  cfg;
  item_t push_item, head_item;
  logic  q_push, q_pop, q_full, q_empty;

  osm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  osm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .detection_id_i (detection_id_i),
    .forward_dist_i (forward_dist_i),
    .left_dist_i    (left_dist_i),
    .confidence_i   (confidence_i),
    .heading_i      (heading_i),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .speed_kph_i    (speed_kph_i),
    .last_item_i    (last_item_i),
    .cfg_i          (cfg),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  osm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  osm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .q_empty_i         (q_empty),
    .q_item_i          (head_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .obstacle_id_o     (obstacle_id_o),
    .world_x_o         (world_x_o),
    .world_y_o         (world_y_o),
    .obstacle_range_o  (obstacle_range_o),
    .emergency_brake_o (emergency_brake_o),
    .nearest_found_o   (nearest_found_o),
    .nearest_id_o      (nearest_id_o),
    .nearest_range_o   (nearest_range_o),
    .frame_done_o      (frame_done_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_accept_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> nearest_found_o)
    else $error("accepted obstacle without nearest");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (world_x_o == '0 && world_y_o == '0))
    else $error("rejected detection with world position");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !nearest_found_o) |-> (nearest_id_o == '0 && nearest_range_o == '0))
    else $error("nearest fields set without nearest");

endmodule

// ----- rtl/core/osm_regs.sv -----
module osm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output osm_pkg::cfg_t              cfg_o
);
  import osm_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_confidence  <= RST_MIN_CONF;
      cfg_q.max_range       <= RST_MAX_RANGE;
      cfg_q.lane_half_width <= RST_LANE;
      cfg_q.reaction_time   <= RST_REACT;
      cfg_q.max_decel       <= RST_DECEL;
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1:2])
        REG_MIN_CONF:  cfg_q.min_confidence  <= pwdata[16:0];
        REG_MAX_RANGE: cfg_q.max_range       <= pwdata[22:0];
        REG_LANE:      cfg_q.lane_half_width <= pwdata[22:0];
        REG_REACT:     cfg_q.reaction_time   <= pwdata[15:0];
        REG_DECEL:     cfg_q.max_decel       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_MIN_CONF:  prdata = {15'b0, cfg_q.min_confidence};
      REG_MAX_RANGE: prdata = {9'b0, cfg_q.max_range};
      REG_LANE:      prdata = {9'b0, cfg_q.lane_half_width};
      REG_REACT:     prdata = {16'b0, cfg_q.reaction_time};
      REG_DECEL:     prdata = {16'b0, cfg_q.max_decel};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/osm_front.sv -----
module osm_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        detection_id_i,
  input  logic signed [23:0] forward_dist_i,
  input  logic signed [23:0] left_dist_i,
  input  logic [16:0]        confidence_i,
  input  logic [15:0]        heading_i,
  input  logic signed [31:0] pose_x_i,
  input  logic signed [31:0] pose_y_i,
  input  logic [15:0]        speed_kph_i,
  input  logic               last_item_i,
  input  osm_pkg::cfg_t      cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output osm_pkg::item_t     q_item_o
);
  import osm_pkg::*;

  logic [23:0] abs_left;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign abs_left   = left_dist_i[23] ? 24'(-left_dist_i) : 24'(left_dist_i);

  always_comb begin
    q_item_o.id      = detection_id_i;
    q_item_o.fwd     = forward_dist_i;
    q_item_o.left    = left_dist_i;
    q_item_o.conf_ok = (confidence_i >= cfg_i.min_confidence) && (confidence_i <= ONE_Q16);
    q_item_o.lane_ok = !forward_dist_i[23] && (abs_left <= {1'b0, cfg_i.lane_half_width});
    q_item_o.heading = heading_i;
    q_item_o.pose_x  = pose_x_i;
    q_item_o.pose_y  = pose_y_i;
    q_item_o.speed   = speed_kph_i;
    q_item_o.last    = last_item_i;
  end

endmodule

// ----- rtl/core/osm_queue.sv -----
module osm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  osm_pkg::item_t item_i,
  input  logic           pop_i,
  output osm_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);
  import osm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/osm_back.sv -----
module osm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  osm_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  osm_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [15:0]        obstacle_id_o,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic [23:0]        obstacle_range_o,
  output logic               emergency_brake_o,
  output logic               nearest_found_o,
  output logic [15:0]        nearest_id_o,
  output logic [23:0]        nearest_range_o,
  output logic               frame_done_o
);
  import osm_pkg::*;

  localparam logic [5:0] C_FF    = 6'd0;
  localparam logic [5:0] C_LL    = 6'd1;
  localparam logic [5:0] C_SR    = 6'd2;
  localparam logic [5:0] C_NUM   = 6'd3;
  localparam logic [5:0] C_NUM2  = 6'd4;
  localparam logic [5:0] C_FA    = 6'd5;
  localparam logic [5:0] C_STOP  = 6'd6;
  localparam logic [5:0] C_SQ0   = 6'd2;
  localparam logic [5:0] C_RND   = 6'(2 + SQRT_STEPS);
  localparam logic [5:0] C_CORD  = 6'(CORDIC_STEPS);
  localparam logic [5:0] C_WX0   = 6'(CORDIC_STEPS);
  localparam logic [5:0] C_WX1   = 6'(CORDIC_STEPS + 1);
  localparam logic [5:0] C_WY0   = 6'(CORDIC_STEPS + 2);
  localparam logic [5:0] C_WY1   = 6'(CORDIC_STEPS + 3);
  localparam logic [5:0] C_FIN   = 6'(CORDIC_STEPS + 4);
  localparam logic [47:0] SQRT_TOP = 48'h4000_0000_0000;

  osm_state_e state_q, state_d;
  logic       fin;

  item_t              item_q;
  logic [5:0]         cnt_q;
  logic [15:0]        decel_q;
  logic [23:0]        a180_q;
  logic [28:0]        s6400_q;
  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [47:0]        n_q, r_q;
  logic               sqz_q;
  logic [23:0]        rng_q;
  logic signed [57:0] ff_q;
  logic [31:0]        t1_q;
  logic [56:0]        num_q;
  logic [38:0]        fa_q;
  logic               stop_ok_q;
  logic signed [58:0] accx_q, accy_q;

  logic [23:0] best_range_q;
  logic [15:0] best_id_q;
  logic        best_valid_q, brake_q;

  logic               out_valid_q, accepted_q, brake_out_q, found_q, done_q;
  logic [15:0]        oid_q, nid_q;
  logic [31:0]        wx_q, wy_q;
  logic [23:0]        orng_q, nrng_q;

  logic [15:0]        aeff_w;
  logic [31:0]        t_in, t_cur;
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] prod;
  logic signed [33:0] c_w, s_w;
  logic [4:0]         ci;
  logic signed [33:0] dx, dy;
  logic signed [31:0] at_w;
  logic [5:0]         sk;
  logic [47:0]        bitv, trial;
  logic [47:0]        rnd_w;
  logic [63:0]        lhs;
  logic signed [57:0] sq_sum;
  logic               ok, take_new;
  logic signed [58:0] rx, ry;
  logic signed [63:0] wx_sum, wy_sum;

  assign aeff_w = (cfg_i.max_decel == '0) ? 16'd1 : cfg_i.max_decel;
  assign t_in   = {q_item_i.heading[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign t_cur  = {item_q.heading[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_RUN;
      ST_RUN:  if (fin) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    fin     = 1'b0;
    unique case (state_q)
      ST_IDLE: q_pop_o = !q_empty_i;
      ST_RUN:  fin = (cnt_q == C_FIN) && (!out_valid_q || !out_stall_i);
      default: ;
    endcase
  end

  // quadrant fold
  always_comb begin
    case (t_cur[31:30])
      2'd0:    begin c_w = x_q;  s_w = y_q;  end
      2'd1:    begin c_w = -y_q; s_w = x_q;  end
      2'd2:    begin c_w = -x_q; s_w = -y_q; end
      default: begin c_w = y_q;  s_w = -x_q; end
    endcase
  end

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cnt_q)
      C_FF:    begin ma = 33'(item_q.fwd);  mb = 25'(item_q.fwd);  end
      C_LL:    begin ma = 33'(item_q.left); mb = 25'(item_q.left); end
      C_SR:    begin ma = {17'b0, item_q.speed}; mb = {9'b0, cfg_i.reaction_time}; end
      C_NUM:   begin ma = {1'b0, t1_q};          mb = {1'b0, a180_q}; end
      C_NUM2:  begin ma = {4'b0, s6400_q};       mb = {9'b0, item_q.speed}; end
      C_FA:    begin ma = 33'(item_q.fwd);       mb = {9'b0, decel_q}; end
      C_WX0:   begin ma = c_w[32:0]; mb = 25'(item_q.fwd);  end
      C_WX1:   begin ma = s_w[32:0]; mb = 25'(item_q.left); end
      C_WY0:   begin ma = s_w[32:0]; mb = 25'(item_q.fwd);  end
      C_WY1:   begin ma = c_w[32:0]; mb = 25'(item_q.left); end
      default: ;
    endcase
  end

  assign prod   = ma * mb;
  assign sq_sum = ff_q + prod;

  assign ci   = cnt_q[4:0];
  assign dx   = y_q >>> ci;
  assign dy   = x_q >>> ci;
  assign at_w = atan_lut(ci);

  assign sk    = cnt_q - C_SQ0;
  assign bitv  = SQRT_TOP >> {sk[4:0], 1'b0};
  assign trial = r_q + bitv;
  assign rnd_w = (n_q > r_q) ? r_q + 48'd1 : r_q;

  assign lhs = ({25'b0, fa_q} * 64'd648) << (16 - DIST_FRAC_BITS);

  assign ok       = item_q.conf_ok && !sqz_q && (rng_q <= {1'b0, cfg_i.max_range});
  assign take_new = ok && (!best_valid_q || (rng_q < best_range_q));

  assign rx     = (accx_q + 59'sd536870912) >>> 30;
  assign ry     = (accy_q + 59'sd536870912) >>> 30;
  assign wx_sum = 64'(item_q.pose_x) + 64'(rx);
  assign wy_sum = 64'(item_q.pose_y) + 64'(ry);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q  <= q_item_i;
      decel_q <= aeff_w;
      a180_q  <= 24'({8'b0, aeff_w} * 24'd180);
      s6400_q <= 29'({13'b0, q_item_i.speed} * 29'd6400);
      x_q     <= CORDIC_GAIN;
      y_q     <= '0;
      z_q     <= {2'b00, t_in[29:0]};
    end else if (state_q == ST_RUN) begin
      if (cnt_q < C_CORD) begin
        if (!z_q[31]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at_w;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at_w;
        end
      end
      if (cnt_q == C_FF) ff_q <= prod;
      if (cnt_q == C_LL) begin
        n_q   <= sq_sum[47:0];
        r_q   <= '0;
        sqz_q <= (sq_sum == '0);
      end
      if (cnt_q >= C_SQ0 && cnt_q < C_RND) begin
        if (n_q >= trial) begin
          n_q <= n_q - trial;
          r_q <= (r_q >> 1) + bitv;
        end else begin
          r_q <= r_q >> 1;
        end
      end
      if (cnt_q == C_RND) begin
        rng_q <= (rnd_w > 48'hFFFFFF) ? 24'hFFFFFF : rnd_w[23:0];
      end
      if (cnt_q == C_SR)   t1_q <= prod[31:0];
      if (cnt_q == C_NUM)  num_q <= prod[56:0];
      if (cnt_q == C_NUM2) num_q <= num_q + prod[56:0];
      if (cnt_q == C_FA)   fa_q <= prod[38:0];
      if (cnt_q == C_STOP) stop_ok_q <= (lhs <= {7'b0, num_q});
      if (cnt_q == C_WX0)  accx_q <= 59'(prod);
      if (cnt_q == C_WX1)  accx_q <= accx_q - 59'(prod);
      if (cnt_q == C_WY0)  accy_q <= 59'(prod);
      if (cnt_q == C_WY1)  accy_q <= accy_q + 59'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      accepted_q  <= ok;
      oid_q       <= item_q.id;
      wx_q        <= ok ? sat32(wx_sum) : '0;
      wy_q        <= ok ? sat32(wy_sum) : '0;
      orng_q      <= rng_q;
      brake_out_q <= brake_q || (ok && item_q.lane_ok && stop_ok_q);
      found_q     <= best_valid_q || ok;
      nid_q       <= take_new ? item_q.id : best_id_q;
      nrng_q      <= take_new ? rng_q : best_range_q;
      done_q      <= item_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      best_range_q <= '0;
      best_id_q    <= '0;
      best_valid_q <= 1'b0;
      brake_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ST_RUN && cnt_q != C_FIN) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin) begin
        if (item_q.last) begin
          best_range_q <= '0;
          best_id_q    <= '0;
          best_valid_q <= 1'b0;
          brake_q      <= 1'b0;
        end else begin
          if (take_new) begin
            best_range_q <= rng_q;
            best_id_q    <= item_q.id;
          end
          best_valid_q <= best_valid_q || ok;
          brake_q      <= brake_q || (ok && item_q.lane_ok && stop_ok_q);
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign obstacle_id_o     = oid_q;
  assign world_x_o         = wx_q;
  assign world_y_o         = wy_q;
  assign obstacle_range_o  = orng_q;
  assign emergency_brake_o = brake_out_q;
  assign nearest_found_o   = found_q;
  assign nearest_id_o      = nid_q;
  assign nearest_range_o   = nrng_q;
  assign frame_done_o      = done_q;

endmodule

// ----- verif/obstacle_safety_monitor_unit_tb.sv -----
`timescale 1ns / 1ps

module obstacle_safety_monitor_unit_tb;
  import osm_pkg::*;

  localparam int  REG_UNUSED  = 5;
  localparam int  LIMIT       = 1000000;
  localparam int  SETTLE      = 60;
  localparam int  ITEMS_PHASE = 360;

  typedef struct {
    logic [15:0]        id;
    logic signed [23:0] fwd;
    logic signed [23:0] left;
    logic [16:0]        conf;
    logic [15:0]        heading;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        speed;
    logic               last;
  } detection_t;

  typedef struct {
    logic        accepted;
    logic [15:0] obstacle_id;
    logic [31:0] world_x;
    logic [31:0] world_y;
    logic [23:0] obstacle_range;
    logic        brake;
    logic        found;
    logic [15:0] nearest_id;
    logic [23:0] nearest_range;
    logic        frame_done;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] detection_id_i = '0;
  logic signed [23:0] forward_dist_i = '0, left_dist_i = '0;
  logic [16:0] confidence_i = '0;
  logic [15:0] heading_i = '0;
  logic signed [31:0] pose_x_i = '0, pose_y_i = '0;
  logic [15:0] speed_kph_i = '0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o;
  logic [15:0] obstacle_id_o;
  logic [31:0] world_x_o, world_y_o;
  logic [23:0] obstacle_range_o;
  logic emergency_brake_o, nearest_found_o;
  logic [15:0] nearest_id_o;
  logic [23:0] nearest_range_o;
  logic frame_done_o;

  obstacle_safety_monitor_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // own copy of the block's registers and frame state
  longint unsigned cfg_min_conf, cfg_max_range, cfg_lane, cfg_react, cfg_decel;
  longint unsigned frame_best_range, frame_best_id;
  bit frame_best_valid, frame_brake;
  longint turn_steps [30];

  outcome_t pending_outcomes [$];
  int mismatches = 0;
  int idle_mode = 0;
  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[obstacle_safety_monitor_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case (idle_mode)
      0:       out_stall_i <= ($urandom_range(99) < 47);
      1:       out_stall_i <= ($urandom_range(99) < 14);
      default: out_stall_i <= 1'b0;
    endcase
  end

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_nearest(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  task automatic rotate_turn(input logic [31:0] t, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    z = longint'({2'b00, t[29:0]});
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - turn_steps[i];
      end else begin
        x = x + dx; y = y - dy; z = z + turn_steps[i];
      end
    end
    case (t[31:30])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endtask

  task automatic predict_outcome(input detection_t d, output outcome_t o);
    longint f, l, px, py, c, s, wx, wy, al, stop;
    longint unsigned sq, rng, a, num, den, q, rem;
    bit ok;
    f = d.fwd;
    l = d.left;
    px = d.pose_x;
    py = d.pose_y;
    sq = f * f + l * l;
    rng = root_nearest(sq);
    if (rng > 64'hFFFFFF) rng = 64'hFFFFFF;
    ok = d.conf >= cfg_min_conf && d.conf <= 65536 && sq != 0 && rng <= cfg_max_range;
    wx = 0;
    wy = 0;
    if (ok) begin
      rotate_turn({d.heading, 16'h0000}, c, s);
      wx = sat_word(px + ((c * f - s * l + (64'sd1 << 29)) >>> 30));
      wy = sat_word(py + ((s * f + c * l + (64'sd1 << 29)) >>> 30));
      if (!frame_best_valid || rng < frame_best_range) begin
        frame_best_valid = 1;
        frame_best_range = rng;
        frame_best_id = d.id;
      end
      a = (cfg_decel != 0) ? cfg_decel : 1;
      num = 180 * longint'(d.speed) * cfg_react * a + 6400 * longint'(d.speed) * d.speed;
      den = 648 * a * 65536;
      q = num / den;
      rem = num % den;
      stop = longint'((q << 8) + ((rem << 8) / den));
      al = (l < 0) ? -l : l;
      if (f >= 0 && al <= longint'(cfg_lane) && f <= stop) frame_brake = 1;
    end
    o.accepted = ok;
    o.obstacle_id = d.id;
    o.world_x = wx[31:0];
    o.world_y = wy[31:0];
    o.obstacle_range = rng[23:0];
    o.brake = frame_brake;
    o.found = frame_best_valid;
    o.nearest_id = frame_best_valid ? frame_best_id[15:0] : 16'd0;
    o.nearest_range = frame_best_valid ? frame_best_range[23:0] : 24'd0;
    o.frame_done = d.last;
    if (d.last) begin
      frame_best_valid = 0; frame_brake = 0; frame_best_range = 0; frame_best_id = 0;
    end
  endtask

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        e = pending_outcomes.pop_front();
        check_field("accepted", e.accepted, accepted_o);
        check_field("obstacle_id", e.obstacle_id, obstacle_id_o);
        check_field("world_x", e.world_x, world_x_o);
        check_field("world_y", e.world_y, world_y_o);
        check_field("obstacle_range", e.obstacle_range, obstacle_range_o);
        check_field("emergency_brake", e.brake, emergency_brake_o);
        check_field("nearest_found", e.found, nearest_found_o);
        check_field("nearest_id", e.nearest_id, nearest_id_o);
        check_field("nearest_range", e.nearest_range, nearest_range_o);
        check_field("frame_done", e.frame_done, frame_done_o);
      end
    end
  end

  task automatic send_detection(input detection_t d);
    outcome_t o;
    int pct;
    pct = (idle_mode == 0) ? 14 : (idle_mode == 1) ? 47 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    detection_id_i <= d.id;
    forward_dist_i <= d.fwd;
    left_dist_i <= d.left;
    confidence_i <= d.conf;
    heading_i <= d.heading;
    pose_x_i <= d.pose_x;
    pose_y_i <= d.pose_y;
    speed_kph_i <= d.speed;
    last_item_i <= d.last;
    do @(posedge clk_i); while (in_stall_o);
    predict_outcome(d, o);
    pending_outcomes = {pending_outcomes, o};
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_CONF:  cfg_min_conf = val & 32'h1FFFF;
      REG_MAX_RANGE: cfg_max_range = val & 32'h7FFFFF;
      REG_LANE:      cfg_lane = val & 32'h7FFFFF;
      REG_REACT:     cfg_react = val & 32'hFFFF;
      REG_DECEL:     cfg_decel = val & 32'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic detection_t make_detection(input logic signed [23:0] f,
      input logic signed [23:0] l, input logic [16:0] conf, input logic [15:0] hd,
      input logic signed [31:0] px, input logic signed [31:0] py, input logic [15:0] spd,
      input logic last);
    detection_t d;
    d.id = 16'($urandom);
    d.fwd = f; d.left = l; d.conf = conf; d.heading = hd;
    d.pose_x = px; d.pose_y = py; d.speed = spd; d.last = last;
    return d;
  endfunction

  task automatic test_directed_defaults();
    send_detection(make_detection(0, 0, 65536, 0, 0, 0, 1000, 0));
    send_detection(make_detection(100, 0, 65536, 0, 256, -256, 65535, 0));
    send_detection(make_detection(12800, 0, 32768, 16384, 0, 0, 0, 0));
    send_detection(make_detection(12801, 0, 65536, 0, 0, 0, 0, 0));
    send_detection(make_detection(200, 384, 32767, 0, 0, 0, 9000, 0));
    send_detection(make_detection(200, 384, 65537, 0, 0, 0, 9000, 1));
    send_detection(make_detection(300, -384, 40000, 32768, 1000, 1000, 9000, 0));
    send_detection(make_detection(300, -385, 40000, 49152, 1000, 1000, 9000, 0));
    send_detection(make_detection(-5, 7, 131071, 65535, 0, 0, 9000, 0));
    send_detection(make_detection(-1000, 2000, 50000, 12345, -2000, 7, 0, 1));
    send_detection(make_detection(-24'sd8388608, -24'sd8388608, 65536, 0,
                                  32'sh7FFFFFFF, 32'sh80000000, 65535, 0));
    send_detection(make_detection(24'sd8388607, 24'sd8388607, 0, 65535,
                                  32'sh80000000, 32'sh7FFFFFFF, 65535, 0));
    send_detection(make_detection(500, 0, 60000, 8192, 0, 0, 3000, 0));
    send_detection(make_detection(0, 500, 60000, 8192, 0, 0, 3000, 0));
    send_detection(make_detection(1, 1, 60000, 40000, 0, 0, 3000, 1));
    wait_quiet();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MIN_CONF, 0);
    write_reg(REG_MAX_RANGE, 32'h7FFFFF);
    write_reg(REG_LANE, 32'h7FFFFF);
    write_reg(REG_REACT, 32'hFFFF);
    write_reg(REG_DECEL, 0);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_detection(make_detection(24'sd8388607, 0, 0, 0, 32'sh7FFFFFFF, 0, 65535, 0));
    send_detection(make_detection(-24'sd8388608, 0, 1, 0, 32'sh80000000, 0, 65535, 0));
    send_detection(make_detection(0, 24'sd8388607, 65536, 16384, 32'sh7FFFFFFF,
                                  32'sh7FFFFFFF, 65535, 0));
    send_detection(make_detection(5000000, -24'sd8388608, 100, 24576, 32'sh80000000,
                                  32'sh80000000, 65535, 1));
    wait_quiet();
    write_reg(REG_MIN_CONF, 32'h1FFFF);
    write_reg(REG_MAX_RANGE, 0);
    write_reg(REG_LANE, 0);
    write_reg(REG_REACT, 0);
    write_reg(REG_DECEL, 32'hFFFF);
    send_detection(make_detection(10, 0, 65536, 0, 0, 0, 65535, 0));
    send_detection(make_detection(1, 0, 131071, 0, 0, 0, 65535, 1));
    wait_quiet();
    write_reg(REG_MIN_CONF, 0);
    write_reg(REG_MAX_RANGE, 32'h7FFFFF);
    send_detection(make_detection(10, 0, 0, 0, 0, 0, 65535, 0));
    send_detection(make_detection(20, 0, 65536, 0, 0, 0, 0, 1));
    wait_quiet();
  endtask

  task automatic test_random_frames(input int mode);
    detection_t d;
    int remaining, frame_len, lim;
    logic [15:0] hd, spd;
    logic signed [31:0] px, py;
    idle_mode = mode;
    write_reg(REG_MIN_CONF, $urandom_range(0, 70000));
    write_reg(REG_MAX_RANGE, ($urandom_range(9) == 0) ? $urandom : $urandom_range(500, 40000));
    write_reg(REG_LANE, $urandom_range(0, 2000));
    write_reg(REG_REACT, $urandom);
    write_reg(REG_DECEL, $urandom_range(0, 65535));
    remaining = ITEMS_PHASE;
    while (remaining > 0) begin
      frame_len = $urandom_range(1, 8);
      hd = 16'($urandom);
      spd = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
      px = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
      py = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
      for (int k = 0; k < frame_len && remaining > 0; k++) begin
        lim = ($urandom_range(1) == 0) ? 3000 : 800;
        d.id = 16'($urandom);
        d.fwd = ($urandom_range(9) < 7) ? 24'($signed($urandom_range(0, 2 * lim)) - lim)
                                        : 24'($urandom);
        d.left = ($urandom_range(9) < 7) ? 24'($signed($urandom_range(0, lim)) - lim / 2)
                                         : 24'($urandom);
        d.conf = ($urandom_range(9) < 7) ? 17'($urandom_range(0, 65536) | cfg_min_conf)
                                         : 17'($urandom);
        if (d.conf > 65536 && $urandom_range(1) == 0) d.conf = 65536;
        d.heading = ($urandom_range(4) == 0) ? 16'($urandom) : hd;
        d.pose_x = px;
        d.pose_y = py;
        d.speed = spd;
        d.last = (k == frame_len - 1) ? 1'b1 : ($urandom_range(19) == 0);
        send_detection(d);
        remaining--;
      end
    end
    wait_quiet();
  endtask

  initial begin
    turn_steps = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    cfg_min_conf = 32768;
    cfg_max_range = 12800;
    cfg_lane = 384;
    cfg_react = 128;
    cfg_decel = 1536;
    frame_best_range = 0;
    frame_best_id = 0;
    frame_best_valid = 0;
    frame_brake = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_register_extremes();
    test_random_frames(0);
    test_random_frames(1);
    test_random_frames(2);
    if (pending_outcomes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[obstacle_safety_monitor_unit] OK");
    end else begin
      $display("[obstacle_safety_monitor_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/osm_pkg.sv
rtl/core/osm_regs.sv
rtl/core/osm_front.sv
rtl/core/osm_queue.sv
rtl/core/osm_back.sv
rtl/core/obstacle_safety_monitor_unit.sv
verif/obstacle_safety_monitor_unit_tb.sv
